FILE: hw/rtl/mtbs_pkg.sv
// ----------------------------------------------------------------------------
// mtbs_pkg
// Shared types and constants of the masked texel bilinear sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package mtbs_pkg;

	// fixed port field widths
	localparam int COORD_W      = 16;
	localparam int PORT_COLOR_W = 16;
	localparam int ADDR_IN_W    = 12;
	localparam int CFG_W        = 7;
	localparam int IN_DATA_W    = 96;
	localparam int OUT_DATA_W   = 48;
	localparam int KIND_W       = 2;

	localparam logic [6:0] RESET_ROW_STRIDE  = 7'd64;
	localparam logic [6:0] RESET_ROW_COUNT   = 7'd64;
	localparam logic [1:0] RESET_SAMPLE_MODE = 2'd1;
	localparam logic       RESET_MASK_ENABLE = 1'b1;

	localparam logic [1:0] MODE_NEAREST  = 2'd0;
	localparam logic [1:0] MODE_FALLBACK = 2'd1;
	localparam logic [1:0] MODE_STRICT   = 2'd2;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		REG_ROW_STRIDE  = 2'd0,
		REG_ROW_COUNT   = 2'd1,
		REG_SAMPLE_MODE = 2'd2,
		REG_MASK_ENABLE = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_RANGE  = 2'd2
	} item_kind_t;

	typedef enum logic [1:0] {
		STATUS_BILINEAR = 2'd0,
		STATUS_NEAREST  = 2'd1,
		STATUS_MASKED   = 2'd2,
		STATUS_RANGE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_PICK,
		ST_OUT
	} back_state_t;

	typedef struct packed {
		logic [1:0] sample_mode;
		logic       mask_enable;
	} back_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mtbs_front.sv
// ----------------------------------------------------------------------------
// mtbs_front
// Classifies incoming transactions: texel writes, in-range samples with their
// top-left store address, and samples whose neighbourhood leaves the image.
// ----------------------------------------------------------------------------
`default_nettype none

module mtbs_front #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int COLOR_BITS = 16,
	parameter int FRAC_BITS  = 8,
	localparam int DEPTH  = MAX_ROWS * MAX_COLS,
	localparam int AW     = $clog2(DEPTH),
	localparam int CW     = $clog2(MAX_COLS + 1),
	localparam int ITEM_W = mtbs_pkg::KIND_W + 1 + 3 * COLOR_BITS + 2 * FRAC_BITS + CW + AW
) (
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// addr[11:0] red[27:12] green[43:28] blue[59:44] usable[60]
	// coord_row[76:61] coord_col[92:77], zero fill above
	input  wire logic [mtbs_pkg::IN_DATA_W-1:0] s_tdata,
	// req_type[0]
	input  wire logic                           s_tuser,
	input  wire logic [mtbs_pkg::CFG_W-1:0]     row_stride,
	input  wire logic [mtbs_pkg::CFG_W-1:0]     row_count,
	output logic                                q_valid,
	input  wire logic                           q_ready,
	output logic [ITEM_W-1:0]                   q_data
);

	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int RBW = $clog2(MAX_ROWS);
	localparam int CBW = $clog2(MAX_COLS);
	localparam int IW  = mtbs_pkg::COORD_W - FRAC_BITS;
	localparam int PW  = RBW + CW;

	logic [mtbs_pkg::ADDR_IN_W-1:0]    addr_in;
	logic [mtbs_pkg::PORT_COLOR_W-1:0] red_in, green_in, blue_in;
	logic                              usable_in;
	logic [mtbs_pkg::COORD_W-1:0]      coord_row, coord_col;
	logic [CW-1:0]                     stride_c;
	logic [RW-1:0]                     rows_c;
	logic [IW-1:0]                     r_int, c_int;
	logic [PW-1:0]                     row_base;
	logic [AW-1:0]                     a0, item_addr;
	logic                              is_write, drop, oor;
	mtbs_pkg::item_kind_t              kind;

	assign addr_in   = s_tdata[11:0];
	assign red_in    = s_tdata[27:12];
	assign green_in  = s_tdata[43:28];
	assign blue_in   = s_tdata[59:44];
	assign usable_in = s_tdata[60];
	assign coord_row = s_tdata[76:61];
	assign coord_col = s_tdata[92:77];

	// saturate the geometry registers into the legal range
	always_comb begin
		if (row_stride == '0) begin
			stride_c = CW'(1);
		end else if (32'(row_stride) > MAX_COLS) begin
			stride_c = CW'(MAX_COLS);
		end else begin
			stride_c = CW'(row_stride);
		end
		if (row_count == '0) begin
			rows_c = RW'(1);
		end else if (32'(row_count) > MAX_ROWS) begin
			rows_c = RW'(MAX_ROWS);
		end else begin
			rows_c = RW'(row_count);
		end
	end

	assign r_int = coord_row[mtbs_pkg::COORD_W-1:FRAC_BITS];
	assign c_int = coord_col[mtbs_pkg::COORD_W-1:FRAC_BITS];

	assign oor = (32'(r_int) + 32'd1 >= 32'(rows_c)) || (32'(c_int) + 32'd1 >= 32'(stride_c));

	assign row_base = PW'(r_int[RBW-1:0]) * PW'(stride_c);
	assign a0       = AW'(row_base) + AW'(c_int[CBW-1:0]);

	assign is_write = (s_tuser == mtbs_pkg::REQ_WRITE);
	assign drop     = is_write && (32'(addr_in) >= DEPTH);

	always_comb begin
		if (is_write) begin
			kind      = mtbs_pkg::KIND_WRITE;
			item_addr = AW'(addr_in);
		end else if (oor) begin
			kind      = mtbs_pkg::KIND_RANGE;
			item_addr = a0;
		end else begin
			kind      = mtbs_pkg::KIND_SAMPLE;
			item_addr = a0;
		end
	end

	// writes beyond the store are consumed and dropped
	assign s_tready = q_ready;
	assign q_valid  = s_tvalid && !drop;
	assign q_data   = {kind, usable_in,
		COLOR_BITS'(blue_in), COLOR_BITS'(green_in), COLOR_BITS'(red_in),
		coord_col[FRAC_BITS-1:0], coord_row[FRAC_BITS-1:0], stride_c, item_addr};

endmodule

`default_nettype wire

FILE: hw/rtl/mtbs_queue.sv
// ----------------------------------------------------------------------------
// mtbs_queue
// Two-entry queue between the classifier and the sampling engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mtbs_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [W-1:0] in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [W-1:0]      out_data
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   count_q;
	logic         push, pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= in_data;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mtbs_back.sv
// ----------------------------------------------------------------------------
// mtbs_back
// Sampling engine: owns the texel store, reads four neighbours one per cycle,
// blends them, picks the nearest usable one or returns zeros; holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mtbs_back #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int COLOR_BITS = 16,
	parameter int FRAC_BITS  = 8,
	localparam int DEPTH  = MAX_ROWS * MAX_COLS,
	localparam int AW     = $clog2(DEPTH),
	localparam int CW     = $clog2(MAX_COLS + 1),
	localparam int ITEM_W = mtbs_pkg::KIND_W + 1 + 3 * COLOR_BITS + 2 * FRAC_BITS + CW + AW
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mtbs_pkg::back_cfg_t               cfg,
	input  wire logic                              q_valid,
	output logic                                   q_ready,
	input  wire logic [ITEM_W-1:0]                 q_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [mtbs_pkg::PORT_COLOR_W-1:0]      red_out,
	output logic [mtbs_pkg::PORT_COLOR_W-1:0]      green_out,
	output logic [mtbs_pkg::PORT_COLOR_W-1:0]      blue_out,
	output mtbs_pkg::status_t                      sample_status
);

	localparam int CB  = COLOR_BITS;
	localparam int F   = FRAC_BITS;
	localparam int TW  = 3 * CB + 1;
	localparam int WW  = 2 * F + 1;
	localparam int DW  = 2 * F + 2;
	localparam int ACW = CB + 2 * F;
	localparam int MW  = CB + 2 * F + 1;

	// queue head fields
	logic [AW-1:0]        h_addr;
	logic [CW-1:0]        h_stride;
	logic [F-1:0]         h_fr, h_fc;
	logic [3*CB-1:0]      h_color;
	logic                 h_use;
	mtbs_pkg::item_kind_t h_kind;

	assign h_addr   = q_data[AW-1:0];
	assign h_stride = q_data[AW +: CW];
	assign h_fr     = q_data[AW+CW +: F];
	assign h_fc     = q_data[AW+CW+F +: F];
	assign h_color  = q_data[AW+CW+2*F +: 3*CB];
	assign h_use    = q_data[AW+CW+2*F+3*CB];
	assign h_kind   = mtbs_pkg::item_kind_t'(q_data[ITEM_W-1 -: mtbs_pkg::KIND_W]);

	mtbs_pkg::back_state_t state_q, state_d;
	logic [2:0]            cyc_q;
	logic                  rd_en, mem_we;
	logic [AW-1:0]         rd_addr;

	logic [TW-1:0]  mem [DEPTH];
	logic [TW-1:0]  rd_s1;
	logic           v_s1, v_s2;
	logic [1:0]     k_s1;
	logic [ACW-1:0] prod_s2 [3];
	logic [ACW-1:0] acc_q [3];
	logic [MW-1:0]  mul_full [3];

	logic [AW-1:0]  a0_q;
	logic [CW-1:0]  stride_q;
	logic [WW-1:0]  w_q [4];
	logic [DW-1:0]  d_q [4];
	logic [CB-1:0]  col_q [4][3];
	logic [3:0]     use_q;

	logic [mtbs_pkg::PORT_COLOR_W-1:0] res_q [3];
	mtbs_pkg::status_t                 status_q;

	// weights and squared distances of the head item
	logic [F:0]    fr_x, fc_x, gr_x, gc_x;
	logic [WW-1:0] w_d [4];
	logic [WW-1:0] sq_fr, sq_fc, sq_gr, sq_gc;
	logic [DW-1:0] d_d [4];

	assign fr_x = {1'b0, h_fr};
	assign fc_x = {1'b0, h_fc};
	assign gr_x = (F+1)'(1) << F;
	assign gc_x = gr_x - fc_x;

	logic [F:0] grr_x;
	assign grr_x = gr_x - fr_x;

	assign w_d[0] = WW'(grr_x) * WW'(gc_x);
	assign w_d[1] = WW'(grr_x) * WW'(fc_x);
	assign w_d[2] = WW'(fr_x) * WW'(gc_x);
	assign w_d[3] = WW'(fr_x) * WW'(fc_x);
	assign sq_fr  = WW'(fr_x) * WW'(fr_x);
	assign sq_fc  = WW'(fc_x) * WW'(fc_x);
	assign sq_gr  = WW'(grr_x) * WW'(grr_x);
	assign sq_gc  = WW'(gc_x) * WW'(gc_x);
	assign d_d[0] = DW'(sq_fr) + DW'(sq_fc);
	assign d_d[1] = DW'(sq_fr) + DW'(sq_gc);
	assign d_d[2] = DW'(sq_gr) + DW'(sq_fc);
	assign d_d[3] = DW'(sq_gr) + DW'(sq_gc);

	// neighbour k: bit 0 steps one column, bit 1 steps one row
	assign rd_addr = a0_q + (cyc_q[1] ? AW'(stride_q) : AW'(0)) + AW'(cyc_q[0]);

	always_comb begin
		state_d   = state_q;
		q_ready   = 1'b0;
		rd_en     = 1'b0;
		mem_we    = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			mtbs_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_ready = 1'b1;
					unique case (h_kind)
						mtbs_pkg::KIND_WRITE:  mem_we = 1'b1;
						mtbs_pkg::KIND_SAMPLE: state_d = mtbs_pkg::ST_READ;
						default:               state_d = mtbs_pkg::ST_OUT;
					endcase
				end
			end
			mtbs_pkg::ST_READ: begin
				rd_en = (cyc_q < 3'd4);
				if (cyc_q == 3'd5) state_d = mtbs_pkg::ST_PICK;
			end
			mtbs_pkg::ST_PICK: begin
				state_d = mtbs_pkg::ST_OUT;
			end
			mtbs_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = mtbs_pkg::ST_IDLE;
			end
			default: state_d = mtbs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtbs_pkg::ST_IDLE;
			cyc_q   <= 3'd0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			cyc_q   <= (state_q == mtbs_pkg::ST_READ) ? cyc_q + 3'd1 : 3'd0;
			v_s1    <= rd_en;
			v_s2    <= v_s1;
		end
	end

	// texel store
	always_ff @(posedge clk) begin
		if (mem_we) mem[h_addr] <= {h_use, h_color};
		if (rd_en) rd_s1 <= mem[rd_addr];
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			mul_full[ch] = MW'(rd_s1[ch*CB +: CB]) * MW'(w_q[k_s1]);
		end
	end

	// nearest usable texel, ties to the earlier one
	logic [3:0]    use_k;
	logic          all_use, found;
	logic [DW-1:0] best;
	logic [1:0]    pick;

	always_comb begin
		found = 1'b0;
		best  = '0;
		pick  = 2'd0;
		for (int k = 0; k < 4; k++) begin
			use_k[k] = (cfg.sample_mode == mtbs_pkg::MODE_NEAREST) || !cfg.mask_enable
				|| use_q[k];
			if (use_k[k] && (!found || d_q[k] < best)) begin
				found = 1'b1;
				best  = d_q[k];
				pick  = 2'(k);
			end
		end
		all_use = &use_k;
	end

	always_ff @(posedge clk) begin
		k_s1 <= cyc_q[1:0];
		if (state_q == mtbs_pkg::ST_IDLE && q_valid) begin
			a0_q     <= h_addr;
			stride_q <= h_stride;
			for (int k = 0; k < 4; k++) begin
				w_q[k] <= w_d[k];
				d_q[k] <= d_d[k];
			end
			for (int ch = 0; ch < 3; ch++) begin
				acc_q[ch] <= ACW'(1) << (2 * F - 1);
				res_q[ch] <= '0;
			end
			status_q <= mtbs_pkg::STATUS_RANGE;
		end
		if (v_s1) begin
			for (int ch = 0; ch < 3; ch++) begin
				prod_s2[ch]       <= ACW'(mul_full[ch]);
				col_q[k_s1][ch]   <= rd_s1[ch*CB +: CB];
			end
			use_q[k_s1] <= rd_s1[3*CB];
		end
		if (v_s2) begin
			for (int ch = 0; ch < 3; ch++) begin
				acc_q[ch] <= acc_q[ch] + prod_s2[ch];
			end
		end
		if (state_q == mtbs_pkg::ST_PICK) begin
			priority if (all_use && cfg.sample_mode != mtbs_pkg::MODE_NEAREST) begin
				for (int ch = 0; ch < 3; ch++) begin
					res_q[ch] <= mtbs_pkg::PORT_COLOR_W'(acc_q[ch] >> (2 * F));
				end
				status_q <= mtbs_pkg::STATUS_BILINEAR;
			end else if (cfg.sample_mode >= mtbs_pkg::MODE_STRICT) begin
				for (int ch = 0; ch < 3; ch++) begin
					res_q[ch] <= '0;
				end
				status_q <= mtbs_pkg::STATUS_MASKED;
			end else begin
				for (int ch = 0; ch < 3; ch++) begin
					res_q[ch] <= mtbs_pkg::PORT_COLOR_W'(col_q[pick][ch]);
				end
				status_q <= mtbs_pkg::STATUS_NEAREST;
			end
		end
	end

	assign red_out       = res_q[0];
	assign green_out     = res_q[1];
	assign blue_out      = res_q[2];
	assign sample_status = status_q;

endmodule

`default_nettype wire

FILE: hw/rtl/masked_texel_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// masked_texel_bilinear_sampler
// Texel store with usable bits and a bilinear / nearest sampling engine.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tuser selects a texel write (0) or a sample (1). A write
//   stores one texel and produces no output; a write beyond the store is
//   dropped. A sample produces exactly one output transaction on m_*, in order.
//   Configuration writes on cfg_* are always ready and take effect at once;
//   issue them only while no transaction is in flight.
//   Result path: a sample's result goes through the queue, four single-port
//   reads of the texel store, multiply and accumulate, and pick before it
//   appears on m_*; a sample outside the image skips the reads and the pick.
//   Throughput: one write per cycle while the engine is idle; a sample
//   occupies the engine until its result is taken, reading the four
//   neighbours one per cycle from one port. The two-entry queue keeps
//   accepting input while a result waits, until it is full.
//   Reset: registers return to stride 64, rows 64, fallback mode, mask on;
//   the texel store is not cleared and must be written before it is sampled.
//   Output stall: the result holds on m_* until m_tready; the engine waits.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_texel_bilinear_sampler #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int COLOR_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// texel_addr[11:0] red_in[27:12] green_in[43:28] blue_in[59:44]
	// texel_usable[60] coord_row[76:61] coord_col[92:77], zeros [95:93]
	input  wire logic [mtbs_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type[0]
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// red_out[15:0] green_out[31:16] blue_out[47:32]
	output logic [mtbs_pkg::OUT_DATA_W-1:0]      m_tdata,
	// sample_status[1:0]
	output logic [1:0]                           m_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [mtbs_pkg::CFG_W-1:0]      cfg_data
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(MAX_COLS + 1);
	localparam int ITEM_W = mtbs_pkg::KIND_W + 1 + 3 * COLOR_BITS + 2 * FRAC_BITS + CW + AW;

	logic [mtbs_pkg::CFG_W-1:0] row_stride_q, row_count_q;
	logic [1:0]                 sample_mode_q;
	logic                       mask_enable_q;
	mtbs_pkg::back_cfg_t        back_cfg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_stride_q  <= mtbs_pkg::RESET_ROW_STRIDE;
			row_count_q   <= mtbs_pkg::RESET_ROW_COUNT;
			sample_mode_q <= mtbs_pkg::RESET_SAMPLE_MODE;
			mask_enable_q <= mtbs_pkg::RESET_MASK_ENABLE;
		end else if (cfg_valid) begin
			unique case (mtbs_pkg::reg_index_t'(cfg_index))
				mtbs_pkg::REG_ROW_STRIDE:  row_stride_q  <= cfg_data;
				mtbs_pkg::REG_ROW_COUNT:   row_count_q   <= cfg_data;
				mtbs_pkg::REG_SAMPLE_MODE: sample_mode_q <= cfg_data[1:0];
				mtbs_pkg::REG_MASK_ENABLE: mask_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign back_cfg.sample_mode = sample_mode_q;
	assign back_cfg.mask_enable = mask_enable_q;

	logic              fq_valid, fq_ready, bq_valid, bq_ready;
	logic [ITEM_W-1:0] fq_data, bq_data;

	mtbs_front #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.COLOR_BITS(COLOR_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.row_stride(row_stride_q),
		.row_count (row_count_q),
		.q_valid   (fq_valid),
		.q_ready   (fq_ready),
		.q_data    (fq_data)
	);

	mtbs_queue #(
		.W(ITEM_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fq_valid),
		.in_ready (fq_ready),
		.in_data  (fq_data),
		.out_valid(bq_valid),
		.out_ready(bq_ready),
		.out_data (bq_data)
	);

	logic [mtbs_pkg::PORT_COLOR_W-1:0] red_out, green_out, blue_out;
	mtbs_pkg::status_t                 sample_status;

	mtbs_back #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.COLOR_BITS(COLOR_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (back_cfg),
		.q_valid      (bq_valid),
		.q_ready      (bq_ready),
		.q_data       (bq_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.sample_status(sample_status)
	);

	assign m_tdata = {blue_out, green_out, red_out};
	assign m_tuser = sample_status;

endmodule

`default_nettype wire

FILE: tb/tb_masked_texel_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// tb_masked_texel_bilinear_sampler
// Self-checking bench: texel writes and samples over several register settings,
// predicted colours and status checked in order, with random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

class texel_sample_board;
	logic [15:0] color [4096][3];
	bit          usable [4096];
	bit          written [4096];
	int          stride, rows;
	logic [1:0]  mode;
	bit          mask_on;
	logic [49:0] pending_samples [$];
	int          mismatches;

	function void reset_regs();
		stride = 64; rows = 64; mode = mtbs_pkg::MODE_FALLBACK; mask_on = 1;
	endfunction

	function void write_reg(mtbs_pkg::reg_index_t idx, int val);
		case (idx)
		mtbs_pkg::REG_ROW_STRIDE: stride = val & 7'h7f;
		mtbs_pkg::REG_ROW_COUNT: rows = val & 7'h7f;
		mtbs_pkg::REG_SAMPLE_MODE: mode = val[1:0];
		mtbs_pkg::REG_MASK_ENABLE: mask_on = val[0];
		endcase
	endfunction

	function void note_input(logic req, logic [95:0] d);
		int a, r1, c1, fr, fc, gr, gc, s, n, k, ch, pick, best;
		int addr [4];
		longint wt [4];
		int dsq [4];
		bit use_k [4];
		bit all_use, found;
		longint acc;
		logic [15:0] res [3];
		logic [1:0] st;
		if (req == mtbs_pkg::REQ_WRITE) begin
			a = int'(d[11:0]);
			color[a][0] = d[27:12]; color[a][1] = d[43:28]; color[a][2] = d[59:44];
			usable[a] = d[60]; written[a] = 1;
			return;
		end
		s = (stride < 1) ? 1 : (stride > 64 ? 64 : stride);
		n = (rows < 1) ? 1 : (rows > 64 ? 64 : rows);
		r1 = int'(d[76:69]); fr = int'(d[68:61]); c1 = int'(d[92:85]); fc = int'(d[84:77]);
		res[0] = '0; res[1] = '0; res[2] = '0;
		if (r1 + 1 >= n || c1 + 1 >= s) begin
			st = mtbs_pkg::STATUS_RANGE;
		end else begin
			addr[0] = r1 * s + c1; addr[1] = addr[0] + 1;
			addr[2] = addr[0] + s; addr[3] = addr[2] + 1;
			gr = 256 - fr; gc = 256 - fc;
			wt[0] = gr * gc; wt[1] = gr * fc; wt[2] = fr * gc; wt[3] = fr * fc;
			dsq[0] = fr*fr + fc*fc; dsq[1] = fr*fr + gc*gc;
			dsq[2] = gr*gr + fc*fc; dsq[3] = gr*gr + gc*gc;
			all_use = 1;
			for (k = 0; k < 4; k++) begin
				use_k[k] = mode == mtbs_pkg::MODE_NEAREST || !mask_on || usable[addr[k]];
				all_use &= use_k[k];
			end
			if (all_use && mode != mtbs_pkg::MODE_NEAREST) begin
				for (ch = 0; ch < 3; ch++) begin
					acc = 32768;
					for (k = 0; k < 4; k++) acc += longint'(color[addr[k]][ch]) * wt[k];
					res[ch] = 16'(acc >> 16);
				end
				st = mtbs_pkg::STATUS_BILINEAR;
			end else if (mode >= mtbs_pkg::MODE_STRICT) begin
				st = mtbs_pkg::STATUS_MASKED;
			end else begin
				pick = 0; found = 0; best = 0;
				for (k = 0; k < 4; k++)
					if (use_k[k] && (!found || dsq[k] < best)) begin
						found = 1; best = dsq[k]; pick = k;
					end
				for (ch = 0; ch < 3; ch++) res[ch] = color[addr[pick]][ch];
				st = mtbs_pkg::STATUS_NEAREST;
			end
		end
		pending_samples.push_back({st, res[2], res[1], res[0]});
	endfunction

	function void check_result(logic [47:0] d, logic [1:0] st);
		logic [49:0] want;
		if (pending_samples.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %h status %0d", d, st);
			return;
		end
		want = pending_samples.pop_front();
		if (want[47:0] !== d || want[49:48] !== st) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected rgb %h st %0d, got rgb %h st %0d",
					want[47:0], want[49:48], d, st);
		end
	endfunction
endclass

module tb_masked_texel_bilinear_sampler;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0, arst_n = 0;
	logic        s_tvalid = 0, s_tready, s_tuser = 0;
	logic [95:0] s_tdata = '0;
	logic        m_tvalid, m_tready = 0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 0, cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	texel_sample_board board = new();
	int  send_idle_pct = 0, stall_pct = 0, hold_off = 0, idle_cycles = 0;
	bit  timed_out = 0;

	masked_texel_bilinear_sampler dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000 && !timed_out) begin
			timed_out = 1;
			$display("TEST FAILED");
			$finish;
		end
	end

	// valid stays high into the next transaction; drop it only while idling
	task automatic send_item(logic req, logic [95:0] d);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1; s_tuser <= req; s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_input(req, d);
	endtask

	task automatic write_texel(int a, logic [15:0] r, g, b, bit u);
		send_item(mtbs_pkg::REQ_WRITE, {35'd0, u, b, g, r, a[11:0]});
	endtask

	task automatic sample_at(logic [15:0] row, logic [15:0] col);
		logic [95:0] d;
		d = '0;
		d[76:61] = row; d[92:77] = col;
		d[60:0] = 61'({$urandom, $urandom});
		send_item(mtbs_pkg::REQ_SAMPLE, d);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending_samples.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_reg(mtbs_pkg::reg_index_t idx, int val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val[6:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// fill the whole active image so no unwritten entry is ever read
	task automatic fill_image();
		int a;
		for (a = 0; a < board.stride * board.rows && a < 4096; a++)
			write_texel(a, 16'($urandom), 16'($urandom), 16'($urandom),
				$urandom_range(3) != 0);
	endtask

	task automatic sample_random(int count);
		int r, c;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0) begin
				sample_at(16'($urandom), 16'($urandom));
			end else if ($urandom_range(5) == 0) begin
				write_texel($urandom_range(board.stride * board.rows - 1),
					16'($urandom), 16'($urandom), 16'($urandom), $urandom_range(1));
			end else begin
				r = $urandom_range(board.rows > 1 ? board.rows - 2 : 0);
				c = $urandom_range(board.stride > 1 ? board.stride - 2 : 0);
				sample_at({r[7:0], 8'($urandom)}, {c[7:0], 8'($urandom)});
			end
		end
	endtask

	initial begin
		int strides [6] = '{16, 2, 5, 64, 1, 3};
		int rcounts [6] = '{16, 2, 4, 5, 64, 1};
		board.reset_regs();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, ties, masked neighbours, far corner of the store
		write_texel(0, 16'hffff, 16'hffff, 16'hffff, 1);
		write_texel(1, 16'h0000, 16'h0000, 16'h0000, 0);
		write_texel(64, 16'hffff, 16'h0000, 16'hffff, 1);
		write_texel(65, 16'h0000, 16'hffff, 16'h0000, 0);
		write_texel(4030, 16'h1234, 16'h8000, 16'hfffe, 1);
		write_texel(4031, 16'h0001, 16'h7fff, 16'h00ff, 1);
		write_texel(4094, 16'hff00, 16'h0f0f, 16'h5555, 1);
		write_texel(4095, 16'h0001, 16'h0002, 16'h0003, 1);
		send_item(mtbs_pkg::REQ_WRITE, {34'd0, 1'b1, 1'b1, 48'hffff_ffff_ffff, 12'hfff});
		sample_at(16'h0000, 16'h0000);
		sample_at(16'h0080, 16'h0080);
		sample_at(16'h00ff, 16'h00ff);
		sample_at(16'h0080, 16'h0000);
		sample_at(16'h3eff, 16'h3eff);
		sample_at(16'h3f00, 16'h0000);
		sample_at(16'hffff, 16'hffff);
		for (int m = 0; m < 4; m++) begin
			drain();
			set_reg(mtbs_pkg::REG_SAMPLE_MODE, m);
			sample_at(16'h0080, 16'h0080);
			sample_at(16'h0040, 16'h00c0);
		end
		drain();
		set_reg(mtbs_pkg::REG_MASK_ENABLE, 0);
		sample_at(16'h0080, 16'h0080);
		drain();
		set_reg(mtbs_pkg::REG_ROW_STRIDE, 0);
		set_reg(mtbs_pkg::REG_ROW_COUNT, 127);
		sample_at(16'h0000, 16'h0000);
		drain();

		// random phases across settings and idling profiles
		for (int p = 0; p < 6; p++) begin
			set_reg(mtbs_pkg::REG_ROW_STRIDE, strides[p]);
			set_reg(mtbs_pkg::REG_ROW_COUNT, rcounts[p]);
			set_reg(mtbs_pkg::REG_SAMPLE_MODE, $urandom_range(3));
			set_reg(mtbs_pkg::REG_MASK_ENABLE, $urandom_range(1));
			fill_image();
			case (p % 4)
			0: begin send_idle_pct = 0; stall_pct = 0; end
			1: begin send_idle_pct = 55; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 55; end
			default: begin send_idle_pct = 33; stall_pct = 33; end
			endcase
			if (p == 2) hold_off = 400;
			sample_random(p == 0 ? 250 : 200);
			drain();
		end

		wait (board.pending_samples.size() == 0);
		repeat (30) @(posedge clk);
		if (board.mismatches == 0 && board.pending_samples.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

`default_nettype wire

FILE: files.f
hw/rtl/mtbs_pkg.sv
hw/rtl/mtbs_front.sv
hw/rtl/mtbs_queue.sv
hw/rtl/mtbs_back.sv
hw/rtl/masked_texel_bilinear_sampler.sv
tb/tb_masked_texel_bilinear_sampler.sv
